>>> hdl/cpuopalu_pkg.sv
// Shared types, codes and register-file helpers for the micro-op ALU core.
// No dependencies; imported by cpu_micro_op_alu_register_file_core.
`default_nettype none

package cpuopalu_pkg;

	typedef enum logic [4:0] {
		ACT_ADD    = 5'd0,
		ACT_ADC    = 5'd1,
		ACT_SUB    = 5'd2,
		ACT_AND    = 5'd3,
		ACT_OR     = 5'd4,
		ACT_XOR    = 5'd5,
		ACT_CP     = 5'd6,
		ACT_INC8   = 5'd7,
		ACT_DEC8   = 5'd8,
		ACT_RLA    = 5'd9,
		ACT_RLCA   = 5'd10,
		ACT_RRA    = 5'd11,
		ACT_RRCA   = 5'd12,
		ACT_RR     = 5'd13,
		ACT_SLA    = 5'd14,
		ACT_SRL    = 5'd15,
		ACT_SWAP   = 5'd16,
		ACT_BIT    = 5'd17,
		ACT_RES    = 5'd18,
		ACT_CPL    = 5'd19,
		ACT_CCF    = 5'd20,
		ACT_SCF    = 5'd21,
		ACT_INC16  = 5'd22,
		ACT_DEC16  = 5'd23,
		ACT_ADD_HL = 5'd24,
		ACT_LOAD   = 5'd25
	} action_t;

	localparam logic [2:0] SEL_B   = 3'd0;
	localparam logic [2:0] SEL_C   = 3'd1;
	localparam logic [2:0] SEL_D   = 3'd2;
	localparam logic [2:0] SEL_E   = 3'd3;
	localparam logic [2:0] SEL_H   = 3'd4;
	localparam logic [2:0] SEL_L   = 3'd5;
	localparam logic [2:0] SEL_OPD = 3'd6;
	localparam logic [2:0] SEL_A   = 3'd7;

	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
		logic [7:0] e;
		logic [7:0] h;
		logic [7:0] l;
		logic [7:0] a;
	} regfile_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	function automatic logic [7:0] sel_read(regfile_t rf, logic [2:0] sel, logic [7:0] opd);
		logic [7:0] v;
		case (sel)
			SEL_B:   v = rf.b;
			SEL_C:   v = rf.c;
			SEL_D:   v = rf.d;
			SEL_E:   v = rf.e;
			SEL_H:   v = rf.h;
			SEL_L:   v = rf.l;
			SEL_A:   v = rf.a;
			default: v = opd;
		endcase
		return v;
	endfunction

	function automatic regfile_t sel_write(regfile_t rf, logic [2:0] sel, logic [7:0] v);
		regfile_t r;
		r = rf;
		case (sel)
			SEL_B:   r.b = v;
			SEL_C:   r.c = v;
			SEL_D:   r.d = v;
			SEL_E:   r.e = v;
			SEL_H:   r.h = v;
			SEL_L:   r.l = v;
			SEL_A:   r.a = v;
			default: r = rf;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hdl/cpu_micro_op_alu_register_file_core.sv
// Top level of the micro-op ALU core: input register, ALU and register file, result register.
// Depends on cpuopalu_pkg.
`default_nettype none

// The core takes one micro-op per clock cycle and returns one result per micro-op; each goes
// from the input register to the result register. A micro-op sits in the input register
// while the ALU works on the current register file, flags and stack pointer; the new state is
// written in the same edge that moves the result into the output register, so the next
// micro-op in the following cycle already sees it. With both registers full and the output
// stalled, in_ready drops until the output transfer frees a place.
module cpu_micro_op_alu_register_file_core
	import cpuopalu_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [4:0]  action,
	input  wire logic [2:0]  source_sel,
	input  wire logic [2:0]  dest_sel,
	input  wire logic [7:0]  operand_byte,
	input  wire logic [2:0]  bit_index,
	input  wire logic [1:0]  pair_sel,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       result_byte,
	output logic [15:0]      result_word,
	output logic             flag_zero,
	output logic             flag_subtract,
	output logic             flag_half_carry,
	output logic             flag_carry
);

	logic       valid_s1;
	action_t    action_s1;
	logic [2:0] src_sel_s1;
	logic [2:0] dst_sel_s1;
	logic [7:0] operand_s1;
	logic [2:0] bit_s1;
	logic [1:0] pair_s1;

	logic       valid_s2;
	logic [7:0] rbyte_s2;
	logic [15:0] rword_s2;
	flags_t     flags_s2;

	regfile_t   rf_q;
	flags_t     flags_q;
	logic [15:0] sp_q;

	regfile_t   rf_nxt;
	flags_t     flags_nxt;
	logic [15:0] sp_nxt;
	logic [7:0] rb;
	logic [15:0] rw;

	logic       adv;
	logic       take;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign take     = in_valid && in_ready;

	always_comb begin
		logic [7:0]  a;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic        cin;
		logic [8:0]  sum9;
		logic [4:0]  lo5;
		logic        cadd;
		logic [15:0] pval;
		logic [15:0] hl;
		logic [16:0] s17;
		logic [12:0] s13;
		a     = rf_q.a;
		cin   = flags_q.c;
		src   = sel_read(rf_q, src_sel_s1, operand_s1);
		dst   = sel_read(rf_q, dst_sel_s1, operand_s1);
		cadd  = (action_s1 == ACT_ADC) ? cin : 1'b0;
		sum9  = {1'b0, a} + {1'b0, src} + {8'd0, cadd};
		lo5   = {1'b0, a[3:0]} + {1'b0, src[3:0]} + {4'd0, cadd};
		case (pair_s1)
			PAIR_BC: pval = {rf_q.b, rf_q.c};
			PAIR_DE: pval = {rf_q.d, rf_q.e};
			PAIR_HL: pval = {rf_q.h, rf_q.l};
			default: pval = sp_q;
		endcase
		hl    = {rf_q.h, rf_q.l};
		s17   = {1'b0, pval} + {1'b0, hl};
		s13   = {1'b0, pval[11:0]} + {1'b0, hl[11:0]};
		rf_nxt    = rf_q;
		flags_nxt = flags_q;
		sp_nxt    = sp_q;
		rb        = 8'd0;
		rw        = 16'd0;
		case (action_s1)
			ACT_ADD, ACT_ADC: begin
				rb = sum9[7:0];
				rf_nxt.a = rb;
				flags_nxt = '{z: (rb == 8'd0), n: 1'b0, h: lo5[4], c: sum9[8]};
			end
			ACT_SUB, ACT_CP: begin
				rb = a - src;
				if (action_s1 == ACT_SUB) begin
					rf_nxt.a = rb;
				end
				flags_nxt = '{z: (rb == 8'd0), n: 1'b1, h: (a[3:0] < src[3:0]), c: (a < src)};
			end
			ACT_AND: begin
				rb = a & src;
				rf_nxt.a = rb;
				flags_nxt = '{z: (rb == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
			end
			ACT_OR, ACT_XOR: begin
				rb = (action_s1 == ACT_OR) ? (a | src) : (a ^ src);
				rf_nxt.a = rb;
				flags_nxt = '{z: (rb == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			ACT_INC8: begin
				rb = dst + 8'd1;
				rf_nxt = sel_write(rf_q, dst_sel_s1, rb);
				flags_nxt = '{z: (rb == 8'd0), n: 1'b0, h: (dst[3:0] == 4'hF), c: cin};
			end
			ACT_DEC8: begin
				rb = dst - 8'd1;
				rf_nxt = sel_write(rf_q, dst_sel_s1, rb);
				flags_nxt = '{z: (rb == 8'd0), n: 1'b1, h: (dst[3:0] == 4'h0), c: cin};
			end
			ACT_RLA, ACT_RLCA: begin
				rb = {a[6:0], (action_s1 == ACT_RLA) ? cin : a[7]};
				rf_nxt.a = rb;
				flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
			end
			ACT_RRA, ACT_RRCA: begin
				rb = {(action_s1 == ACT_RRA) ? cin : a[0], a[7:1]};
				rf_nxt.a = rb;
				flags_nxt = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
			end
			ACT_RR, ACT_SRL: begin
				rb = {(action_s1 == ACT_RR) ? cin : 1'b0, dst[7:1]};
				rf_nxt = sel_write(rf_q, dst_sel_s1, rb);
				flags_nxt = '{z: (rb == 8'd0), n: 1'b0, h: 1'b0, c: dst[0]};
			end
			ACT_SLA: begin
				rb = {dst[6:0], 1'b0};
				rf_nxt = sel_write(rf_q, dst_sel_s1, rb);
				flags_nxt = '{z: (rb == 8'd0), n: 1'b0, h: 1'b0, c: dst[7]};
			end
			ACT_SWAP: begin
				rb = {dst[3:0], dst[7:4]};
				rf_nxt = sel_write(rf_q, dst_sel_s1, rb);
				flags_nxt = '{z: (rb == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			ACT_BIT: begin
				rb = src;
				flags_nxt = '{z: !src[bit_s1], n: 1'b0, h: 1'b1, c: cin};
			end
			ACT_RES: begin
				rb = dst & ~(8'd1 << bit_s1);
				rf_nxt = sel_write(rf_q, dst_sel_s1, rb);
			end
			ACT_CPL: begin
				rb = ~a;
				rf_nxt.a = rb;
				flags_nxt.n = 1'b1;
				flags_nxt.h = 1'b1;
			end
			ACT_CCF, ACT_SCF: begin
				rb = a;
				flags_nxt = '{z: flags_q.z, n: 1'b0, h: 1'b0,
					c: (action_s1 == ACT_CCF) ? !cin : 1'b1};
			end
			ACT_INC16, ACT_DEC16: begin
				rw = (action_s1 == ACT_INC16) ? (pval + 16'd1) : (pval - 16'd1);
				case (pair_s1)
					PAIR_BC: {rf_nxt.b, rf_nxt.c} = rw;
					PAIR_DE: {rf_nxt.d, rf_nxt.e} = rw;
					PAIR_HL: {rf_nxt.h, rf_nxt.l} = rw;
					default: sp_nxt = rw;
				endcase
			end
			ACT_ADD_HL: begin
				rw = s17[15:0];
				{rf_nxt.h, rf_nxt.l} = rw;
				flags_nxt = '{z: flags_q.z, n: 1'b0, h: s13[12], c: s17[16]};
			end
			ACT_LOAD: begin
				rb = src;
				rf_nxt = sel_write(rf_q, dst_sel_s1, rb);
			end
			default: begin
				rb = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			rf_q     <= '0;
			flags_q  <= '0;
			sp_q     <= 16'd0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
				rf_q     <= rf_nxt;
				flags_q  <= flags_nxt;
				sp_q     <= sp_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1  <= action_t'(action);
			src_sel_s1 <= source_sel;
			dst_sel_s1 <= dest_sel;
			operand_s1 <= operand_byte;
			bit_s1     <= bit_index;
			pair_s1    <= pair_sel;
		end
		if (adv) begin
			rbyte_s2 <= rb;
			rword_s2 <= rw;
			flags_s2 <= flags_nxt;
		end
	end

	assign out_valid       = valid_s2;
	assign result_byte     = rbyte_s2;
	assign result_word     = rword_s2;
	assign flag_zero       = flags_s2.z;
	assign flag_subtract   = flags_s2.n;
	assign flag_half_carry = flags_s2.h;
	assign flag_carry      = flags_s2.c;

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && valid_s2))
		else $error("Input stalled while a pipeline register was free.");

	a_s1_moves_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("A held micro-op did not move into a free result register.");

	a_sp_only_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(sp_q))
		else $error("Stack pointer changed without a micro-op completing.");

	a_word_ops_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (action_s1 == ACT_INC16 || action_s1 == ACT_DEC16 || action_s1 == ACT_ADD_HL))
		|=> (result_byte == 8'd0))
		else $error("A 16-bit micro-op returned a nonzero result byte.");

	a_ccf_scf_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (action_s1 == ACT_CCF || action_s1 == ACT_SCF))
		|=> (!flag_subtract && !flag_half_carry && $past(flags_q.z) == flag_zero))
		else $error("CCF or SCF produced wrong N, H or Z flags.");

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for cpu_micro_op_alu_register_file_core: a scoreboard class keeps its own
// register file, flags and stack pointer and predicts every result. Depends on cpuopalu_pkg.

import cpuopalu_pkg::*;

typedef struct packed {
	logic [4:0] act;
	logic [2:0] src_sel;
	logic [2:0] dst_sel;
	logic [7:0] operand;
	logic [2:0] bit_num;
	logic [1:0] pair;
} micro_op_t;

typedef struct packed {
	logic [7:0]  value8;
	logic [15:0] value16;
	flags_t      flags;
} alu_result_t;

class micro_op_scoreboard;
	logic [7:0]  regs [8];
	flags_t      flags;
	logic [15:0] stack_ptr;
	alu_result_t pending_results [$];
	logic [31:0] actions_seen;
	int unsigned transfers_in;
	int unsigned checked;
	int unsigned failures;

	function new();
		foreach (regs[i]) regs[i] = 8'h00;
		flags = '0;
		stack_ptr = 16'h0000;
		actions_seen = '0;
		transfers_in = 0;
		checked = 0;
		failures = 0;
	endfunction

	function logic [7:0] read_sel(logic [2:0] sel, logic [7:0] operand);
		return (sel == SEL_OPD) ? operand : regs[sel];
	endfunction

	function void write_sel(logic [2:0] sel, logic [7:0] value);
		if (sel != SEL_OPD)
			regs[sel] = value;
	endfunction

	function logic [15:0] read_pair(logic [1:0] pair);
		return (pair == PAIR_SP) ? stack_ptr : {regs[{pair, 1'b0}], regs[{pair, 1'b1}]};
	endfunction

	function void write_pair(logic [1:0] pair, logic [15:0] value);
		if (pair == PAIR_SP) begin
			stack_ptr = value;
		end else begin
			regs[{pair, 1'b0}] = value[15:8];
			regs[{pair, 1'b1}] = value[7:0];
		end
	endfunction

	function void note_transfer(micro_op_t op);
		logic [7:0]  acc;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [7:0]  rb;
		logic [15:0] rw;
		logic [15:0] pv;
		logic [15:0] hl;
		logic [8:0]  sum;
		logic [4:0]  nib;
		logic [16:0] wide;
		logic [12:0] wide_low;
		logic        cin;
		logic        cadd;
		logic        cout;
		alu_result_t want;
		acc = regs[SEL_A];
		cin = flags.c;
		src = read_sel(op.src_sel, op.operand);
		dst = read_sel(op.dst_sel, op.operand);
		rb = '0;
		rw = '0;
		actions_seen[op.act] = 1'b1;
		transfers_in++;
		case (op.act)
			ACT_ADD, ACT_ADC: begin
				cadd = (op.act == ACT_ADC) ? cin : 1'b0;
				sum = {1'b0, acc} + {1'b0, src} + {8'd0, cadd};
				nib = {1'b0, acc[3:0]} + {1'b0, src[3:0]} + {4'd0, cadd};
				rb = sum[7:0];
				regs[SEL_A] = rb;
				flags = {rb == 8'h00, 1'b0, nib[4], sum[8]};
			end
			ACT_SUB, ACT_CP: begin
				rb = acc - src;
				if (op.act == ACT_SUB)
					regs[SEL_A] = rb;
				flags = {rb == 8'h00, 1'b1, acc[3:0] < src[3:0], acc < src};
			end
			ACT_AND: begin
				rb = acc & src;
				regs[SEL_A] = rb;
				flags = {rb == 8'h00, 1'b0, 1'b1, 1'b0};
			end
			ACT_OR, ACT_XOR: begin
				rb = (op.act == ACT_OR) ? (acc | src) : (acc ^ src);
				regs[SEL_A] = rb;
				flags = {rb == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			ACT_INC8: begin
				rb = dst + 8'd1;
				flags = {rb == 8'h00, 1'b0, dst[3:0] == 4'hF, cin};
				write_sel(op.dst_sel, rb);
			end
			ACT_DEC8: begin
				rb = dst - 8'd1;
				flags = {rb == 8'h00, 1'b1, dst[3:0] == 4'h0, cin};
				write_sel(op.dst_sel, rb);
			end
			ACT_RLA, ACT_RLCA, ACT_RRA, ACT_RRCA: begin
				if (op.act == ACT_RLA || op.act == ACT_RLCA) begin
					cout = acc[7];
					rb = {acc[6:0], (op.act == ACT_RLA) ? cin : acc[7]};
				end else begin
					cout = acc[0];
					rb = {(op.act == ACT_RRA) ? cin : acc[0], acc[7:1]};
				end
				regs[SEL_A] = rb;
				flags = {1'b0, 1'b0, 1'b0, cout};
			end
			ACT_RR, ACT_SLA, ACT_SRL: begin
				if (op.act == ACT_SLA) begin
					cout = dst[7];
					rb = {dst[6:0], 1'b0};
				end else begin
					cout = dst[0];
					rb = {(op.act == ACT_RR) ? cin : 1'b0, dst[7:1]};
				end
				write_sel(op.dst_sel, rb);
				flags = {rb == 8'h00, 1'b0, 1'b0, cout};
			end
			ACT_SWAP: begin
				rb = {dst[3:0], dst[7:4]};
				write_sel(op.dst_sel, rb);
				flags = {rb == 8'h00, 1'b0, 1'b0, 1'b0};
			end
			ACT_BIT: begin
				rb = src;
				flags = {~src[op.bit_num], 1'b0, 1'b1, cin};
			end
			ACT_RES: begin
				rb = dst & ~(8'h01 << op.bit_num);
				write_sel(op.dst_sel, rb);
			end
			ACT_CPL: begin
				rb = ~acc;
				regs[SEL_A] = rb;
				flags.n = 1'b1;
				flags.h = 1'b1;
			end
			ACT_CCF, ACT_SCF: begin
				rb = acc;
				flags = {flags.z, 1'b0, 1'b0, (op.act == ACT_CCF) ? ~cin : 1'b1};
			end
			ACT_INC16, ACT_DEC16: begin
				rw = read_pair(op.pair) + ((op.act == ACT_INC16) ? 16'h0001 : 16'hFFFF);
				write_pair(op.pair, rw);
			end
			ACT_ADD_HL: begin
				pv = read_pair(op.pair);
				hl = read_pair(PAIR_HL);
				wide = {1'b0, pv} + {1'b0, hl};
				wide_low = {1'b0, pv[11:0]} + {1'b0, hl[11:0]};
				rw = wide[15:0];
				write_pair(PAIR_HL, rw);
				flags = {flags.z, 1'b0, wide_low[12], wide[16]};
			end
			ACT_LOAD: begin
				rb = src;
				write_sel(op.dst_sel, rb);
			end
			default: begin
			end
		endcase
		want.value8 = rb;
		want.value16 = rw;
		want.flags = flags;
		pending_results.push_back(want);
	endfunction

	function void check_result(logic [7:0] rb, logic [15:0] rw, flags_t got);
		alu_result_t want;
		if (pending_results.size() == 0) begin
			$error("Result transfer with no micro-op waiting: byte 0x%0h, word 0x%0h", rb, rw);
			failures++;
			return;
		end
		want = pending_results.pop_front();
		checked++;
		compare_field("result_byte", {8'h00, want.value8}, {8'h00, rb});
		compare_field("result_word", want.value16, rw);
		compare_field("flag_zero", {15'd0, want.flags.z}, {15'd0, got.z});
		compare_field("flag_subtract", {15'd0, want.flags.n}, {15'd0, got.n});
		compare_field("flag_half_carry", {15'd0, want.flags.h}, {15'd0, got.h});
		compare_field("flag_carry", {15'd0, want.flags.c}, {15'd0, got.c});
	endfunction

	function void compare_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
			failures++;
		end
	endfunction
endclass

module testbench;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned RANDOM_BLOCKS = 16;
	localparam int unsigned BLOCK_ITEMS = 100;
	localparam int unsigned PRESSURE_ITEMS = 30;
	localparam int unsigned SINK_HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned LIMIT_CYCLES = 1000000;
	localparam logic [4:0] ACT_UNUSED_LAST = 5'd31;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [4:0]  action;
	logic [2:0]  source_sel;
	logic [2:0]  dest_sel;
	logic [7:0]  operand_byte;
	logic [2:0]  bit_index;
	logic [1:0]  pair_sel;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  result_byte;
	logic [15:0] result_word;
	logic        flag_zero;
	logic        flag_subtract;
	logic        flag_half_carry;
	logic        flag_carry;

	logic        sink_hold_req = 1'b0;
	int unsigned cycle_count;
	micro_op_scoreboard scoreboard;

	micro_op_t directed_ops [27] = '{
		'{ACT_LOAD,        SEL_OPD, SEL_A,   8'hFF, 3'd0, PAIR_BC},
		'{ACT_LOAD,        SEL_OPD, SEL_B,   8'h01, 3'd0, PAIR_BC},
		'{ACT_ADD,         SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_ADC,         SEL_OPD, SEL_A,   8'hFF, 3'd0, PAIR_BC},
		'{ACT_SUB,         SEL_OPD, SEL_A,   8'h01, 3'd0, PAIR_BC},
		'{ACT_CP,          SEL_A,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_AND,         SEL_OPD, SEL_A,   8'h0F, 3'd0, PAIR_BC},
		'{ACT_XOR,         SEL_A,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_OR,          SEL_OPD, SEL_A,   8'h80, 3'd0, PAIR_BC},
		'{ACT_INC8,        SEL_B,   SEL_OPD, 8'hFF, 3'd0, PAIR_BC},
		'{ACT_DEC8,        SEL_B,   SEL_OPD, 8'h00, 3'd0, PAIR_BC},
		'{ACT_RLA,         SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_RLCA,        SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_RRA,         SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_RRCA,        SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_RR,          SEL_B,   SEL_B,   8'h00, 3'd0, PAIR_BC},
		'{ACT_SLA,         SEL_B,   SEL_OPD, 8'h80, 3'd0, PAIR_BC},
		'{ACT_SRL,         SEL_B,   SEL_OPD, 8'h01, 3'd0, PAIR_BC},
		'{ACT_SWAP,        SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_BIT,         SEL_OPD, SEL_A,   8'h80, 3'd7, PAIR_BC},
		'{ACT_RES,         SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_CPL,         SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_CCF,         SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_SCF,         SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_BC},
		'{ACT_DEC16,       SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_SP},
		'{ACT_ADD_HL,      SEL_B,   SEL_A,   8'h00, 3'd0, PAIR_SP},
		'{ACT_UNUSED_LAST, SEL_OPD, SEL_OPD, 8'hFF, 3'd7, PAIR_SP}
	};

	cpu_micro_op_alu_register_file_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.source_sel     (source_sel),
		.dest_sel       (dest_sel),
		.operand_byte   (operand_byte),
		.bit_index      (bit_index),
		.pair_sel       (pair_sel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_byte    (result_byte),
		.result_word    (result_word),
		.flag_zero      (flag_zero),
		.flag_subtract  (flag_subtract),
		.flag_half_carry(flag_half_carry),
		.flag_carry     (flag_carry)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int unsigned ready_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(50, 200);
		return $urandom_range(1, 8);
	endfunction

	function automatic micro_op_t random_op();
		micro_op_t op;
		if ($urandom_range(0, 99) < 4)
			op.act = 5'($urandom_range(ACT_LOAD + 1, ACT_UNUSED_LAST));
		else
			op.act = 5'($urandom_range(ACT_ADD, ACT_LOAD));
		op.src_sel = 3'($urandom_range(SEL_B, SEL_A));
		op.dst_sel = 3'($urandom_range(SEL_B, SEL_A));
		case ($urandom_range(0, 7))
			0: op.operand = 8'h00;
			1: op.operand = 8'hFF;
			2: op.operand = 8'h0F;
			3: op.operand = 8'hF0;
			default: op.operand = 8'($urandom_range(0, 255));
		endcase
		op.bit_num = 3'($urandom_range(0, 7));
		op.pair = 2'($urandom_range(PAIR_BC, PAIR_SP));
		return op;
	endfunction

	task automatic send_op(input micro_op_t op);
		in_valid <= 1'b1;
		action <= op.act;
		source_sel <= op.src_sel;
		dest_sel <= op.dst_sel;
		operand_byte <= op.operand;
		bit_index <= op.bit_num;
		pair_sel <= op.pair;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		scoreboard.note_transfer(op);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain_core();
		if (scoreboard.pending_results.size() != 0) begin
			in_valid <= 1'b0;
			while (scoreboard.pending_results.size() != 0)
				@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			scoreboard.check_result(result_byte, result_word,
				{flag_zero, flag_subtract, flag_half_carry, flag_carry});
	end

	initial begin : result_sink
		int unsigned hold_left;
		int unsigned run_left;
		bit stall_run;
		hold_left = 0;
		run_left = 0;
		stall_run = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left = SINK_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					stall_run = !stall_run;
					run_left = stall_run ? gap_len() : ready_len();
				end
				if (run_left == 0) begin
					stall_run = 1'b0;
					run_left = ready_len();
				end
				run_left--;
				out_ready <= !stall_run;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("Run did not finish within %0d cycles.", LIMIT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		bit burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ADD;
		source_sel = SEL_B;
		dest_sel = SEL_B;
		operand_byte = 8'h00;
		bit_index = 3'd0;
		pair_sel = PAIR_BC;
		scoreboard = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_ops[i]) begin
			send_op(directed_ops[i]);
			pause_sender(gap_len());
		end
		drain_core();
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			burst = ($urandom_range(0, 3) == 0);
			if (blk == 5) begin
				sink_hold_req = 1'b1;
				repeat (PRESSURE_ITEMS) send_op(random_op());
			end
			if (blk == 10)
				drain_core();
			repeat (BLOCK_ITEMS) begin
				send_op(random_op());
				if (!burst)
					pause_sender(gap_len());
			end
		end
		drain_core();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scoreboard.pending_results.size() != 0) begin
			$error("%0d expected results never arrived.", scoreboard.pending_results.size());
			scoreboard.failures++;
		end
		$display("Transferred %0d micro-ops in and checked %0d results.",
			scoreboard.transfers_in, scoreboard.checked);
		$display("Action codes exercised: %0d of 32, including an output hold-off and drains.",
			$countones(scoreboard.actions_seen));
		if (scoreboard.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
